// ----- rtl/ses_pkg.sv -----
package ses_pkg;

  // Widths of the channel fields and configuration registers.
  localparam int CYL_W      = 16;
  localparam int SEEK_W     = 22;
  localparam int CYLS_W     = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Defaults for the top-level parameters.
  localparam int MAX_REQUESTS_DEF  = 32;
  localparam int CYLINDER_BITS_DEF = 16;

  localparam logic [SEEK_W-1:0] SEEK_MAX = '1;
  localparam logic [CYLS_W-1:0] DISK_CYLINDERS_RST = CYLS_W'(200);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_START     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_CYLINDERS = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // store the accepted request
    logic start_batch;  // set up head, seek total and sweep end
    logic scan_start;   // begin a new pass over the store
    logic scan_step;    // advance the pass by one entry
    logic upper;        // ascending pass over entries at or above the head
    logic calc;         // latch the target and its distance
    logic use_end;      // target is the sweep end, not a stored request
    logic commit;       // move the head and present the visit
    logic end_batch;    // clear the batch state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic found;
    logic last_visit;
    logic out_busy;
  } status_t;

endpackage

// ----- rtl/ses_if.sv -----
interface ses_req_if;
  logic                      valid;
  logic                      ready;
  logic [ses_pkg::CYL_W-1:0] request_cylinder;
  logic                      last_request;

  modport source (output valid, output request_cylinder, output last_request, input ready);
  modport sink   (input valid, input request_cylinder, input last_request, output ready);
endinterface

interface ses_visit_if;
  logic                       valid;
  logic                       ready;
  logic [ses_pkg::CYL_W-1:0]  visit_cylinder;
  logic [ses_pkg::SEEK_W-1:0] seek_total;
  logic                       end_of_order;
  logic                       overflowed;

  modport source (output valid, output visit_cylinder, output seek_total,
                  output end_of_order, output overflowed, input ready);
  modport sink   (input valid, input visit_cylinder, input seek_total,
                  input end_of_order, input overflowed, output ready);
endinterface

// ----- rtl/ses_ctrl.sv -----
module ses_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  ses_pkg::status_t status,
  output ses_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DIST  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       upper;
  logic       upper_next;
  logic       accept;

  assign in_ready = (state == S_LOAD);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    upper_next = upper;
    cmd        = '0;
    cmd.upper  = upper;
    unique case (state)
      S_LOAD: begin
        cmd.load = accept;
        if (accept && in_last) begin
          cmd.start_batch = 1'b1;
          cmd.scan_start  = 1'b1;
          upper_next      = 1'b1;
          state_next      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = S_DIST;
        end
      end
      S_DIST: begin
        cmd.calc    = 1'b1;
        cmd.use_end = upper && !status.found;
        // The sweep end closes the ascending pass.
        if (upper && !status.found) begin
          upper_next = 1'b0;
        end
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          if (status.last_visit) begin
            cmd.end_batch = 1'b1;
            state_next    = S_LOAD;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      upper <= 1'b1;
    end else begin
      state <= state_next;
      upper <= upper_next;
    end
  end

endmodule

// ----- rtl/ses_dpath.sv -----
module ses_dpath #(
  parameter int MAX_REQUESTS  = ses_pkg::MAX_REQUESTS_DEF,
  parameter int CYLINDER_BITS = ses_pkg::CYLINDER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ses_pkg::cmd_t               cmd,
  output ses_pkg::status_t            status,
  input  logic [ses_pkg::CYL_W-1:0]   head_start,
  input  logic [ses_pkg::CYLS_W-1:0]  disk_cylinders,
  input  logic [ses_pkg::CYL_W-1:0]   request_cylinder,
  input  logic                        visit_ready,
  output logic                        visit_valid,
  output logic [ses_pkg::CYL_W-1:0]   visit_cylinder,
  output logic [ses_pkg::SEEK_W-1:0]  seek_total,
  output logic                        end_of_order,
  output logic                        overflowed
);

  localparam int CB    = CYLINDER_BITS;
  localparam int AW    = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int IN_W  = (CB < ses_pkg::CYL_W) ? CB : ses_pkg::CYL_W;
  localparam int EW    = ((CB > ses_pkg::CYLS_W) ? CB : ses_pkg::CYLS_W) + 1;
  localparam int SUM_W = ((CB > ses_pkg::SEEK_W) ? CB : ses_pkg::SEEK_W) + 1;

  logic [CB-1:0]             mem [MAX_REQUESTS];
  logic [CNT_W-1:0]          count;
  logic                      drop_flag;
  logic [MAX_REQUESTS-1:0]   served;
  logic [CNT_W-1:0]          emitted;
  logic [CNT_W-1:0]          sidx;
  logic                      rvalid;
  logic [AW-1:0]             ridx;
  logic [CB-1:0]             rdata;
  logic                      best_valid;
  logic [CB-1:0]             best_val;
  logic [AW-1:0]             best_idx;
  logic [CB-1:0]             head_pos;
  logic [ses_pkg::SEEK_W-1:0] acc;
  logic [CB-1:0]             end_cyl;
  logic [CB-1:0]             target;
  logic [AW-1:0]             target_idx;
  logic                      target_req;
  logic [CB-1:0]             move_len;

  logic [CB-1:0]             req_m;
  logic [CB-1:0]             head_m;
  logic [EW-1:0]             cyls_w;
  logic [EW-1:0]             cyls_lim;
  logic [EW-1:0]             cyls_c;
  logic [EW-1:0]             end_w;
  logic                      full;
  logic                      scan_rd;
  logic                      better;
  logic [CB-1:0]             tgt_sel;
  logic [CB-1:0]             dist_calc;
  logic [SUM_W-1:0]          sum;
  logic [ses_pkg::SEEK_W-1:0] acc_new;

  always_comb begin
    req_m    = CB'(request_cylinder[IN_W-1:0]);
    head_m   = CB'(head_start[IN_W-1:0]);
    cyls_w   = EW'(disk_cylinders);
    cyls_lim = EW'(1) << CB;
    if (cyls_w == '0) begin
      cyls_c = EW'(1);
    end else if (cyls_w > cyls_lim) begin
      cyls_c = cyls_lim;
    end else begin
      cyls_c = cyls_w;
    end
    end_w   = cyls_c - EW'(1);
    full    = (count >= CNT_W'(MAX_REQUESTS));
    scan_rd = cmd.scan_step && (sidx < count);

    better = 1'b0;
    if (rvalid && !served[ridx]) begin
      if (cmd.upper) begin
        better = (rdata >= head_m) && (!best_valid || rdata < best_val);
      end else begin
        better = (rdata < head_m) && (!best_valid || rdata > best_val);
      end
    end

    tgt_sel   = cmd.use_end ? end_cyl : best_val;
    dist_calc = (tgt_sel >= head_pos) ? (tgt_sel - head_pos) : (head_pos - tgt_sel);

    sum = SUM_W'(acc) + SUM_W'(move_len);
    if (sum > SUM_W'(ses_pkg::SEEK_MAX)) begin
      acc_new = ses_pkg::SEEK_MAX;
    end else begin
      acc_new = sum[ses_pkg::SEEK_W-1:0];
    end
  end

  assign status.scan_done  = (sidx == count) && !rvalid;
  assign status.found      = best_valid;
  assign status.last_visit = (emitted == count);
  assign status.out_busy   = visit_valid && !visit_ready;

  // Request store: one write port while loading, one registered read port for the passes.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[AW-1:0]] <= req_m;
    end
    if (scan_rd) begin
      rdata <= mem[sidx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      drop_flag   <= 1'b0;
      served      <= '0;
      emitted     <= '0;
      sidx        <= '0;
      rvalid      <= 1'b0;
      best_valid  <= 1'b0;
      visit_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          drop_flag <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.start_batch) begin
        emitted <= '0;
        served  <= '0;
      end
      if (cmd.scan_start) begin
        sidx       <= '0;
        rvalid     <= 1'b0;
        best_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        rvalid <= scan_rd;
        if (scan_rd) begin
          sidx <= sidx + CNT_W'(1);
        end
        if (better) begin
          best_valid <= 1'b1;
        end
      end
      if (cmd.commit) begin
        visit_valid <= 1'b1;
        emitted     <= emitted + CNT_W'(1);
        if (target_req && !cmd.end_batch) begin
          served[target_idx] <= 1'b1;
        end
      end else if (visit_ready) begin
        visit_valid <= 1'b0;
      end
      if (cmd.end_batch) begin
        count     <= '0;
        drop_flag <= 1'b0;
        served    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_rd) begin
      ridx <= sidx[AW-1:0];
    end
    if (cmd.scan_step && better) begin
      best_val <= rdata;
      best_idx <= ridx;
    end
    if (cmd.start_batch) begin
      head_pos <= head_m;
      acc      <= '0;
      end_cyl  <= end_w[CB-1:0];
    end
    if (cmd.calc) begin
      target     <= tgt_sel;
      target_idx <= best_idx;
      target_req <= !cmd.use_end;
      move_len   <= dist_calc;
    end
    if (cmd.commit) begin
      head_pos       <= target;
      acc            <= cmd.end_batch ? '0 : acc_new;
      visit_cylinder <= ses_pkg::CYL_W'(target);
      seek_total     <= acc_new;
      end_of_order   <= cmd.end_batch;
      overflowed     <= drop_flag;
    end
  end

endmodule

// ----- rtl/scan_elevator_scheduler_top.sv -----
// SCAN (elevator) disk scheduler. Cylinder requests arrive on the req channel, one per
// cycle while the block is loading; the request marked last_request closes the batch.
// Up to MAX_REQUESTS requests are kept, and any beyond that are dropped, which sets
// overflowed on every visit of that batch. The visits then leave on the visit channel:
// requests at or above head_start in ascending order, then the sweep end
// (disk_cylinders minus one, zero read as one, clipped to the cylinder range), then the
// requests below head_start in descending order, each with the running seek distance,
// saturating at its field's maximum, and the last marked by end_of_order. With N
// requests stored a batch gives N + 1 visits. Every choice of the next cylinder sweeps
// the request store one entry per cycle through its single registered read port,
// then forms the distance, then, once the output is free, moves the head and updates
// the total. No request is taken while a batch is being emitted, but loading of the
// next batch may begin while the final visit still waits to be taken. Configuration
// is written through cfg_write, cfg_index and cfg_data; the user must write it only
// while the block is idle, since the block itself has no guard for this.
module scan_elevator_scheduler_top #(
  parameter int MAX_REQUESTS  = ses_pkg::MAX_REQUESTS_DEF,
  parameter int CYLINDER_BITS = ses_pkg::CYLINDER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ses_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ses_pkg::CFG_DATA_W-1:0]  cfg_data,
  ses_req_if.sink                         req,
  ses_visit_if.source                     visit
);

  // Configuration registers.
  logic [ses_pkg::CYL_W-1:0]  head_start;
  logic [ses_pkg::CYLS_W-1:0] disk_cylinders;

  ses_pkg::cmd_t    cmd;
  ses_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_start     <= '0;
      disk_cylinders <= ses_pkg::DISK_CYLINDERS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ses_pkg::CFG_HEAD_START:     head_start     <= cfg_data[ses_pkg::CYL_W-1:0];
        ses_pkg::CFG_DISK_CYLINDERS: disk_cylinders <= cfg_data[ses_pkg::CYLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller sequences loading, the passes over the store and each visit.
  ses_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_last  (req.last_request),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the store, the search, the seek total and the output register.
  ses_dpath #(
    .MAX_REQUESTS  (MAX_REQUESTS),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .head_start       (head_start),
    .disk_cylinders   (disk_cylinders),
    .request_cylinder (req.request_cylinder),
    .visit_ready      (visit.ready),
    .visit_valid      (visit.valid),
    .visit_cylinder   (visit.visit_cylinder),
    .seek_total       (visit.seek_total),
    .end_of_order     (visit.end_of_order),
    .overflowed       (visit.overflowed)
  );

  // Closing a batch stops the intake; ready must be low right after the closing request.
  a_last_stops_intake: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.last_request |=> !req.ready)
    else $error("request taken straight after the end of a batch");

  // While a visit other than the final one is pending, the batch is still being emitted.
  a_no_intake_mid_order: assert property (@(posedge clk) disable iff (rst)
    visit.valid && !visit.end_of_order |-> !req.ready)
    else $error("requests taken while a batch is being emitted");

  // Within a batch the seek total never falls.
  a_seek_rises: assert property (@(posedge clk) disable iff (rst)
    visit.valid && visit.ready && !visit.end_of_order |=>
      !visit.valid || (visit.seek_total >= $past(visit.seek_total)))
    else $error("seek total fell within a batch");

endmodule

// ----- bench/ses_schedule_checker.sv -----
module ses_schedule_checker #(
  parameter int MAX_REQUESTS  = ses_pkg::MAX_REQUESTS_DEF,
  parameter int CYLINDER_BITS = ses_pkg::CYLINDER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ses_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ses_pkg::CFG_DATA_W-1:0] cfg_data,
  ses_req_if                             req,
  ses_visit_if                           visit,
  output int                             failures,
  output int                             outstanding,
  output int                             batches,
  output int                             visits_checked,
  output int                             dropped_batches
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYL_SPAN = longint'(1) << CYLINDER_BITS;

  typedef struct packed {
    logic [ses_pkg::CYL_W-1:0]  cylinder;
    logic [ses_pkg::SEEK_W-1:0] seek;
    logic                       last;
    logic                       dropped;
  } visit_t;

  logic [ses_pkg::CYL_W-1:0]  head_cfg;
  logic [ses_pkg::CYLS_W-1:0] cylinders_cfg;
  longint                     pending_cyl [MAX_REQUESTS];
  int                         loaded;
  logic                       drop_seen;
  longint                     head_pos;
  longint                     seek_sum;
  visit_t                     due_visits [$];

  // Move the head to a cylinder and queue the visit that this move produces.
  function automatic void step_to(input longint cyl);
    visit_t v;
    seek_sum += (cyl >= head_pos) ? cyl - head_pos : head_pos - cyl;
    if (seek_sum > longint'(ses_pkg::SEEK_MAX)) seek_sum = longint'(ses_pkg::SEEK_MAX);
    head_pos   = cyl;
    v.cylinder = cyl[ses_pkg::CYL_W-1:0];
    v.seek     = seek_sum[ses_pkg::SEEK_W-1:0];
    v.last     = 1'b0;
    v.dropped  = drop_seen;
    due_visits.push_back(v);
  endfunction

  // Work out the whole SCAN order of the stored batch.
  function automatic void plan_sweep();
    longint sorted [MAX_REQUESTS];
    longint tmp;
    longint head;
    longint span;
    for (int i = 0; i < loaded; i++) sorted[i] = pending_cyl[i];
    for (int i = 0; i < loaded; i++) begin
      for (int j = 0; j + 1 < loaded - i; j++) begin
        if (sorted[j] > sorted[j+1]) begin
          tmp         = sorted[j];
          sorted[j]   = sorted[j+1];
          sorted[j+1] = tmp;
        end
      end
    end
    head = longint'(head_cfg) & (CYL_SPAN - 1);
    span = longint'(cylinders_cfg);
    if (span == 0) span = 1;
    if (span > CYL_SPAN) span = CYL_SPAN;
    head_pos = head;
    seek_sum = 0;
    for (int i = 0; i < loaded; i++)
      if (sorted[i] >= head) step_to(sorted[i]);
    step_to(span - 1);
    for (int i = loaded - 1; i >= 0; i--)
      if (sorted[i] < head) step_to(sorted[i]);
    due_visits[due_visits.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    visit_t want;
    if (rst) begin
      head_cfg        = '0;
      cylinders_cfg   = ses_pkg::DISK_CYLINDERS_RST;
      loaded          = 0;
      drop_seen       = 1'b0;
      due_visits.delete();
      failures        = 0;
      batches         = 0;
      visits_checked  = 0;
      dropped_batches = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ses_pkg::CFG_HEAD_START:     head_cfg      = cfg_data[ses_pkg::CYL_W-1:0];
          ses_pkg::CFG_DISK_CYLINDERS: cylinders_cfg = cfg_data[ses_pkg::CYLS_W-1:0];
          default: ;
        endcase
      end

      // Visits are matched before a closing request can add a new order.
      if (visit.valid && visit.ready) begin
        visits_checked++;
        if (due_visits.size() == 0) begin
          $error("visit to cylinder %0d arrived with no visit outstanding",
                 visit.visit_cylinder);
          failures++;
        end else begin
          want = due_visits.pop_front();
          if (visit.visit_cylinder !== want.cylinder) begin
            $error("visit_cylinder: expected %0d, got %0d", want.cylinder,
                   visit.visit_cylinder);
            failures++;
          end
          if (visit.seek_total !== want.seek) begin
            $error("seek_total: expected %0d, got %0d", want.seek, visit.seek_total);
            failures++;
          end
          if (visit.end_of_order !== want.last) begin
            $error("end_of_order: expected %0d, got %0d", want.last, visit.end_of_order);
            failures++;
          end
          if (visit.overflowed !== want.dropped) begin
            $error("overflowed: expected %0d, got %0d", want.dropped, visit.overflowed);
            failures++;
          end
        end
      end

      if (req.valid && req.ready) begin
        if (loaded < MAX_REQUESTS) begin
          pending_cyl[loaded] = longint'(req.request_cylinder) & (CYL_SPAN - 1);
          loaded++;
        end else begin
          drop_seen = 1'b1;
        end
        if (req.last_request) begin
          plan_sweep();
          batches++;
          if (drop_seen) dropped_batches++;
          loaded    = 0;
          drop_seen = 1'b0;
        end
      end
    end
    outstanding = due_visits.size();
  end

endmodule

// ----- bench/scan_elevator_scheduler_top_tb.sv -----
module scan_elevator_scheduler_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // The run is short, so the limit is a wide margin over the slowest legal run:
  // full batches of 33 visits, each visit a sweep of the store plus receiver stalls.
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD     = 3000;
  localparam int ITEM_TARGET   = 420;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_write;
  logic [ses_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ses_pkg::CFG_DATA_W-1:0] cfg_data;

  int failures, outstanding, batches, visits_checked, dropped_batches;
  int cycle_count  = 0;
  int items_sent   = 0;
  int reg_writes   = 0;
  int send_gap_max = 10;
  int sink_gap_max = 10;
  int hold_off     = 0;

  // Copies of the current settings, used only to steer request values.
  int head_now      = 0;
  int cylinders_now = 200;

  ses_req_if   req_ch ();
  ses_visit_if visit_ch ();

  scan_elevator_scheduler_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .visit     (visit_ch)
  );

  ses_schedule_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req             (req_ch),
    .visit           (visit_ch),
    .failures        (failures),
    .outstanding     (outstanding),
    .batches         (batches),
    .visits_checked  (visits_checked),
    .dropped_batches (dropped_batches)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it is taken. Valid is only
  // lowered when a gap is drawn, so back-to-back requests keep it high throughout.
  task automatic offer_request(input logic [ses_pkg::CYL_W-1:0] cyl, input logic closing);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.request_cylinder <= cyl;
    req_ch.last_request     <= closing;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Called only at the edge where the previous request was taken.
  task automatic stop_offering();
    req_ch.valid <= 1'b0;
  endtask

  // Waits until the checker has seen the closing request, then until every visit
  // already due has been taken, then lets the block come to rest before anything
  // about its settings is changed.
  task automatic settle();
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ses_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ses_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_writes++;
    if (idx == ses_pkg::CFG_HEAD_START) head_now = value & 16'hFFFF;
    else cylinders_now = value & 17'h1FFFF;
  endtask

  // One well-formed batch of n requests, the last of which closes it. The value
  // pattern varies: spread over the whole range, bunched around the head,
  // drawn from a handful of values so that duplicates are common, or bunched
  // around the sweep end so that requests lie beyond it.
  task automatic send_batch(input int n, input int pattern);
    logic [ses_pkg::CYL_W-1:0] pool [4];
    logic [ses_pkg::CYL_W-1:0] cyl;
    for (int k = 0; k < 4; k++) pool[k] = ses_pkg::CYL_W'($urandom_range(0, 16'hFFFF));
    for (int i = 0; i < n; i++) begin
      case (pattern)
        1:       cyl = ses_pkg::CYL_W'(head_now + $urandom_range(0, 600) - 300);
        2:       cyl = pool[$urandom_range(0, 3)];
        3:       cyl = ses_pkg::CYL_W'(cylinders_now + $urandom_range(0, 40) - 20);
        default: cyl = ses_pkg::CYL_W'($urandom_range(0, 16'hFFFF));
      endcase
      offer_request(cyl, i == n - 1);
    end
  endtask

  // The receiver draws its own stall before every visit. A long hold-off asked
  // for by the stimulus replaces one draw and is counted out here.
  initial begin
    int stall;
    visit_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        stall    = hold_off;
        hold_off = 0;
      end else begin
        stall = $urandom_range(0, sink_gap_max);
      end
      if (stall > 0) begin
        visit_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      visit_ch.ready <= 1'b1;
      @(posedge clk);
      while (!visit_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int phase;
    int nbatch;
    int size_pick;
    int size;
    rst                     = 1'b1;
    cfg_write               = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    req_ch.valid            = 1'b0;
    req_ch.request_cylinder = '0;
    req_ch.last_request     = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Settings after reset: head at cylinder 0, 200 cylinders.
    // A request on the head itself, both ends of the field, a duplicate and a
    // request well beyond the sweep end.
    offer_request(16'd0, 1'b0);
    offer_request(16'hFFFF, 1'b0);
    offer_request(16'd199, 1'b0);
    offer_request(16'd0, 1'b0);
    offer_request(16'd500, 1'b0);
    offer_request(16'd37, 1'b1);
    stop_offering();
    settle();

    // Head at the top of the range, the upper bit of the data word set as well,
    // and zero cylinders, which the block takes as one so the sweep ends at 0.
    write_reg(ses_pkg::CFG_HEAD_START, 17'h1FFFF);
    write_reg(ses_pkg::CFG_DISK_CYLINDERS, 0);
    offer_request(16'hFFFF, 1'b0);
    offer_request(16'd0, 1'b0);
    offer_request(16'd1234, 1'b0);
    offer_request(16'hFFFF, 1'b1);
    stop_offering();
    settle();

    // The full cylinder count: the sweep ends at the top of the range. A batch
    // of one request sitting on the head, then requests either side of it.
    write_reg(ses_pkg::CFG_HEAD_START, 100);
    write_reg(ses_pkg::CFG_DISK_CYLINDERS, 65536);
    offer_request(16'd100, 1'b1);
    offer_request(16'd99, 1'b0);
    offer_request(16'd101, 1'b0);
    offer_request(16'd100, 1'b1);
    stop_offering();
    settle();

    // A count above the field's span is clipped; then a single cylinder.
    write_reg(ses_pkg::CFG_HEAD_START, 40000);
    write_reg(ses_pkg::CFG_DISK_CYLINDERS, 17'h1FFFF);
    offer_request(16'hFFFF, 1'b0);
    offer_request(16'd0, 1'b0);
    offer_request(16'd40000, 1'b0);
    offer_request(16'd39999, 1'b1);
    stop_offering();
    settle();
    write_reg(ses_pkg::CFG_DISK_CYLINDERS, 1);
    offer_request(16'd5, 1'b0);
    offer_request(16'd0, 1'b1);
    stop_offering();
    settle();

    // Random part, in phases. Each phase may change the settings, picks how
    // hard each side idles, then sends a few batches back to back.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 1) == 1 || phase == 0) begin
        case ($urandom_range(0, 3))
          0:       write_reg(ses_pkg::CFG_HEAD_START, 0);
          1:       write_reg(ses_pkg::CFG_HEAD_START, 16'hFFFF);
          default: write_reg(ses_pkg::CFG_HEAD_START, $urandom_range(0, 17'h1FFFF));
        endcase
      end
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 6))
          0:       write_reg(ses_pkg::CFG_DISK_CYLINDERS, 0);
          1:       write_reg(ses_pkg::CFG_DISK_CYLINDERS, 1);
          2:       write_reg(ses_pkg::CFG_DISK_CYLINDERS, 65536);
          3:       write_reg(ses_pkg::CFG_DISK_CYLINDERS, $urandom_range(65537, 17'h1FFFF));
          4:       write_reg(ses_pkg::CFG_DISK_CYLINDERS, 200);
          default: write_reg(ses_pkg::CFG_DISK_CYLINDERS, $urandom_range(1, 65536));
        endcase
      end

      if (phase == 0) begin
        // Back pressure: the receiver stops for a long while after the first
        // visit, so the block cannot finish its order and refuses the next
        // batch, while the sender keeps its requests on offer without gaps.
        send_gap_max = 0;
        sink_gap_max = 0;
        hold_off     = LONG_HOLD;
        for (int b = 0; b < 3; b++) send_batch(8, $urandom_range(0, 3));
      end else begin
        send_gap_max = $urandom_range(0, 1) * 10;
        sink_gap_max = $urandom_range(0, 1) * 10;
        nbatch = $urandom_range(1, 4);
        for (int b = 0; b < nbatch; b++) begin
          // Mostly small batches; now and then a full store or one that
          // overflows it, so that requests are dropped.
          size_pick = $urandom_range(0, 9);
          if (size_pick == 0) size = $urandom_range(33, 40);
          else if (size_pick == 1) size = 32;
          else size = $urandom_range(1, 10);
          send_batch(size, $urandom_range(0, 3));
        end
      end
      stop_offering();
      settle();
      phase++;
    end

    $display("Sent %0d requests in %0d batches, %0d of them overflowing; checked %0d visits.",
             items_sent, batches, dropped_batches, visits_checked);
    $display("Made %0d register writes over %0d random phases.", reg_writes, phase);
    if (failures == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ses_pkg.sv
rtl/ses_if.sv
rtl/ses_ctrl.sv
rtl/ses_dpath.sv
rtl/scan_elevator_scheduler_top.sv
bench/ses_schedule_checker.sv
bench/scan_elevator_scheduler_top_tb.sv
